@@ rtl/core/clint_pkg.sv @@
// Shared types and constants of the core-local interruptor.
// Used by clint_decode and core_local_interruptor; depends on nothing.
package clint_pkg;

   localparam int NUM_HARTS = 4;
   localparam int LINE_W    = 4;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_STORE = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [15:0] SOFT_BASE = 16'h0000;
   localparam logic [15:0] CMP_BASE  = 16'h4000;
   localparam logic [15:0] TIME_BASE = 16'hBFF8;
   localparam int SOFT_SPAN = 4 * NUM_HARTS;
   localparam int CMP_SPAN  = 8 * NUM_HARTS;
   localparam int TIME_SPAN = 8;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] offset;
      logic [1:0]  size_log2;
      logic [63:0] write_data;
      logic [63:0] tick_amount;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        fault;
      logic [3:0]  soft_irq_lines;
      logic [3:0]  timer_irq_lines;
   } rsp_type;

   // decoded access, handed from the decoder to the datapath
   typedef struct packed {
      logic        load;
      logic        store;
      logic        fault;
      logic        soft_hit;
      logic        cmp_hit;
      logic        time_hit;
      logic [7:0]  byte_en;
      logic [15:0] rel;      // offset minus the base of the hit window
   } access_type;

endpackage

@@ rtl/core/clint_decode.sv @@
// Address decode: alignment check, window match and byte enables.
// Depends on clint_pkg.
module clint_decode (
   input  clint_pkg::req_type    req,
   output clint_pkg::access_type acc
);

   logic [3:0]  len;
   logic        misaligned;
   logic        is_mem;
   logic [16:0] off_end;
   logic        soft_in_win;
   logic        cmp_in_win;
   logic        time_in_win;

   always_comb begin
      case (req.size_log2)
         2'd0:    begin len = 4'd1; misaligned = 1'b0; end
         2'd1:    begin len = 4'd2; misaligned = req.offset[0]; end
         2'd2:    begin len = 4'd4; misaligned = |req.offset[1:0]; end
         default: begin len = 4'd8; misaligned = |req.offset[2:0]; end
      endcase
   end

   assign is_mem  = (req.cmd == clint_pkg::CMD_LOAD) || (req.cmd == clint_pkg::CMD_STORE);
   assign off_end = {1'b0, req.offset} + 17'(len);

   assign soft_in_win = (req.offset >= clint_pkg::SOFT_BASE) &&
      (off_end <= 17'({1'b0, clint_pkg::SOFT_BASE}) + 17'(clint_pkg::SOFT_SPAN));
   assign cmp_in_win  = (req.offset >= clint_pkg::CMP_BASE) &&
      (off_end <= 17'({1'b0, clint_pkg::CMP_BASE}) + 17'(clint_pkg::CMP_SPAN));
   assign time_in_win = (req.offset >= clint_pkg::TIME_BASE) &&
      (off_end <= 17'({1'b0, clint_pkg::TIME_BASE}) + 17'(clint_pkg::TIME_SPAN));

   always_comb begin
      acc          = '0;
      acc.load     = req.cmd == clint_pkg::CMD_LOAD;
      acc.store    = req.cmd == clint_pkg::CMD_STORE;
      if (is_mem) begin
         if (misaligned) begin
            acc.fault = 1'b1;
         end else if (soft_in_win) begin
            acc.soft_hit = 1'b1;
            acc.rel      = req.offset - clint_pkg::SOFT_BASE;
         end else if (cmp_in_win) begin
            acc.cmp_hit = 1'b1;
            acc.rel     = req.offset - clint_pkg::CMP_BASE;
         end else if (time_in_win) begin
            acc.time_hit = 1'b1;
            acc.rel      = req.offset - clint_pkg::TIME_BASE;
         end else begin
            acc.fault = 1'b1;
         end
         if (!acc.fault) begin
            for (int k = 0; k < 8; k++) begin
               acc.byte_en[k] = 4'(k) < len;
            end
         end
      end
   end

endmodule

@@ rtl/core/core_local_interruptor.sv @@
// Core-local interruptor top: soft words, timer compares, time counter.
// Depends on clint_pkg and clint_decode.
//
//   channel   ports                       beat marked by
//   request   start, busy, req_data       start && !busy
//   response  rsp_valid, rsp_data         rsp_valid (one cycle)
//
// One beat per cycle; busy is never raised.
// A beat passes the request register, then the single pass that
// updates state and loads the response register.
// Interrupt lines in a response reflect state after that beat.
// Reset clears the time counter, compares, soft bits and both valid flags.
// The receiver cannot stall; every response is shown for exactly one cycle.
module core_local_interruptor (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  clint_pkg::req_type req_data,
   output logic               rsp_valid,
   output clint_pkg::rsp_type rsp_data
);

   localparam int N = clint_pkg::NUM_HARTS;

   logic                  req_valid_ff;
   clint_pkg::req_type    req_ff;
   logic                  rsp_valid_ff;
   clint_pkg::rsp_type    rsp_ff;
   clint_pkg::rsp_type    rsp_in;
   logic [63:0]           time_ff;
   logic [63:0]           time_in;
   logic [63:0]           cmp_ff [N];
   logic [63:0]           cmp_in [N];
   logic [N-1:0]          soft_ff;
   logic [N-1:0]          soft_in;
   clint_pkg::access_type acc;

   assign busy = 1'b0;

   clint_decode u_decode (
      .req (req_ff),
      .acc (acc)
   );

   always_comb begin
      logic [15:0] rel_k;
      logic [63:0] rd;
      rel_k   = '0;
      rd      = '0;
      time_in = time_ff;
      cmp_in  = cmp_ff;
      soft_in = soft_ff;
      if (req_valid_ff) begin
         if (req_ff.cmd == clint_pkg::CMD_TICK) begin
            time_in = time_ff + req_ff.tick_amount;
         end
         for (int k = 0; k < 8; k++) begin
            rel_k = acc.rel + 16'(k);
            if (acc.byte_en[k]) begin
               if (acc.soft_hit) begin
                  for (int h = 0; h < N; h++) begin
                     // only the low byte of a soft word holds state
                     if (rel_k[1:0] == 2'd0 && rel_k[15:2] == 14'(h)) begin
                        if (acc.store) soft_in[h] = req_ff.write_data[8*k];
                        if (acc.load) rd[8*k +: 8] = {7'd0, soft_ff[h]};
                     end
                  end
               end
               if (acc.cmp_hit) begin
                  for (int h = 0; h < N; h++) begin
                     if (rel_k[15:3] == 13'(h)) begin
                        if (acc.store) begin
                           cmp_in[h][{rel_k[2:0], 3'd0} +: 8] = req_ff.write_data[8*k +: 8];
                        end
                        if (acc.load) rd[8*k +: 8] = cmp_ff[h][{rel_k[2:0], 3'd0} +: 8];
                     end
                  end
               end
               if (acc.time_hit) begin
                  if (acc.store) time_in[{rel_k[2:0], 3'd0} +: 8] = req_ff.write_data[8*k +: 8];
                  if (acc.load) rd[8*k +: 8] = time_ff[{rel_k[2:0], 3'd0} +: 8];
               end
            end
         end
      end
      rsp_in           = '0;
      rsp_in.read_data = rd;
      rsp_in.fault     = acc.fault;
      for (int i = 0; i < clint_pkg::LINE_W; i++) begin
         if (i < N) begin
            rsp_in.soft_irq_lines[i]  = soft_in[i];
            rsp_in.timer_irq_lines[i] = time_in >= cmp_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         time_ff      <= '0;
         soft_ff      <= '0;
         for (int h = 0; h < N; h++) cmp_ff[h] <= '0;
      end else begin
         req_valid_ff <= start && !busy;
         rsp_valid_ff <= req_valid_ff;
         time_ff      <= time_in;
         soft_ff      <= soft_in;
         cmp_ff       <= cmp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 2))
      else $error("response without a request two cycles earlier");

   a_fault_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault |-> rsp_data.read_data == 64'd0)
      else $error("faulted beat returned data");

   a_time_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |=> $stable(time_ff))
      else $error("time counter moved without a beat");

   a_soft_lines_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.soft_irq_lines[0] == soft_ff[0])
      else $error("soft line disagrees with stored bit");

endmodule
